>>> src/rsds_pkg.sv
`default_nettype none

package rsds_pkg;

  // Configuration register indexes.
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgInner = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgOuter = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCurve = 2'd2;

  // Register widths and reset values.
  localparam int CfgDataW = 16;
  localparam int RadW     = 16;
  localparam int CurveW   = 2;
  localparam logic [RadW-1:0]   InnerReset = 16'd6554;
  localparam logic [RadW-1:0]   OuterReset = 16'd62259;

  // Response curve codes; the unused code behaves as linear.
  localparam logic [CurveW-1:0] CurveLinear = 2'd0;
  localparam logic [CurveW-1:0] CurveQuad   = 2'd1;
  localparam logic [CurveW-1:0] CurveSmooth = 2'd2;

  // Output format: signed deflection, full scale 32767.
  localparam int OutW   = 16;
  localparam int ScaleW = 15;

endpackage

`default_nettype wire

>>> src/rsds_if.sv
`default_nettype none

// Stick sample channel.
interface rsds_sample_if #(parameter int SW = 12) ();
  logic          valid;
  logic          ready;
  logic [SW-1:0] raw_x;
  logic [SW-1:0] raw_y;
  modport source (output valid, raw_x, raw_y, input ready);
  modport sink   (input valid, raw_x, raw_y, output ready);
endinterface

// Shaped deflection channel.
interface rsds_result_if import rsds_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [OutW-1:0] out_x;
  logic signed [OutW-1:0] out_y;
  modport source (output valid, out_x, out_y, input ready);
  modport sink   (input valid, out_x, out_y, output ready);
endinterface

// Configuration write channel.
interface rsds_cfg_if import rsds_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/rsds_front.sv
`default_nettype none

module rsds_front import rsds_pkg::*; #(
  parameter int SW = 12
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  rsds_sample_if.sink     sample_i,
  output logic            push_valid_o,
  input  logic            push_ready_i,
  output logic [4*SW+1:0] push_data_o
);

  localparam logic [SW-1:0] Mid = {1'b1, {(SW-1){1'b0}}};

  logic          valid_q;
  logic          sx_q, sy_q;
  logic [SW-1:0] ax_q, ay_q;
  logic [2*SW-1:0] sq;

  // The stage takes a new item whenever its content moves on to the queue.
  assign sample_i.ready = !valid_q || push_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (sample_i.ready) begin
      valid_q <= sample_i.valid;
    end
  end

  // Center both samples on the midpoint and split into sign and magnitude.
  always_ff @(posedge clk_i) begin
    if (sample_i.ready && sample_i.valid) begin
      sx_q <= sample_i.raw_x < Mid;
      sy_q <= sample_i.raw_y < Mid;
      ax_q <= (sample_i.raw_x < Mid) ? Mid - sample_i.raw_x : sample_i.raw_x - Mid;
      ay_q <= (sample_i.raw_y < Mid) ? Mid - sample_i.raw_y : sample_i.raw_y - Mid;
    end
  end

  // Squared vector length; it fits since each magnitude is at most the midpoint.
  assign sq = (2*SW)'(ax_q) * (2*SW)'(ax_q) + (2*SW)'(ay_q) * (2*SW)'(ay_q);

  assign push_valid_o = valid_q;
  assign push_data_o  = {sx_q, sy_q, ax_q, ay_q, sq};

endmodule

`default_nettype wire

>>> src/rsds_fifo.sv
`default_nettype none

module rsds_fifo #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  logic [W-1:0] push_data_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output logic [W-1:0] pop_data_o
);

  logic [W-1:0] mem_q [2];
  logic         wr_q, rd_q;
  logic [1:0]   cnt_q;
  logic         push, pop;

  assign push_ready_o = cnt_q != 2'd2;
  assign pop_valid_o  = cnt_q != 2'd0;
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;
  assign pop_data_o = mem_q[rd_q];

  // Two-entry queue: pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (pop)  rd_q <= !rd_q;
      if (push && !pop) cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end

endmodule

`default_nettype wire

>>> src/rsds_back.sv
`default_nettype none

module rsds_back import rsds_pkg::*; #(
  parameter int SW = 12,
  parameter int FW = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  logic [4*SW+1:0]   pop_data_i,
  input  logic [RadW-1:0]   inner_i,
  input  logic [RadW-1:0]   outer_i,
  input  logic [CurveW-1:0] curve_i,
  rsds_result_if.source     result_o
);

  localparam int PreW  = 2 + 2*SW;
  localparam int SideW = 3 + 3*SW;
  localparam int FQ    = FW + 1;
  localparam int NW    = SW + ScaleW;
  localparam int Lsh   = (FW >= RadW) ? FW - RadW : 0;
  localparam int Rsh   = (FW < RadW) ? RadW - FW : 0;
  localparam logic [FW:0]   FracOne = {1'b1, {FW{1'b0}}};
  localparam logic [FW+1:0] Three   = {2'b11, {FW{1'b0}}};

  // Whole pipeline advances together whenever the output register can move.
  logic en;
  logic             res_valid_q;
  logic [OutW-1:0]  res_x_q, res_y_q;

  assign en          = !res_valid_q || result_o.ready;
  assign pop_ready_o = en;

  // ---------------------------------------------------------------- sqrt
  logic              s_v    [SW+1];
  logic [2*SW-1:0]   s_sq   [SW+1];
  logic [SW+1:0]     s_rem  [SW+1];
  logic [SW-1:0]     s_root [SW+1];
  logic [PreW-1:0]   s_pre  [SW+1];

  assign s_v[0]    = pop_valid_i;
  assign s_sq[0]   = pop_data_i[2*SW-1:0];
  assign s_rem[0]  = '0;
  assign s_root[0] = '0;
  assign s_pre[0]  = pop_data_i[4*SW+1:2*SW];

  // One result bit of the integer square root per stage.
  for (genvar k = 0; k < SW; k++) begin : g_sqrt
    localparam int B = 2*(SW-1-k);
    logic [SW+3:0] rt, tr, rs;
    logic [SW-1:0] rn;

    always_comb begin
      rt = {s_rem[k], s_sq[k][B+1:B]};
      tr = {2'b00, s_root[k], 2'b01};
      if (rt >= tr) begin
        rs = rt - tr;
        rn = {s_root[k][SW-2:0], 1'b1};
      end else begin
        rs = rt;
        rn = {s_root[k][SW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        s_v[k+1] <= 1'b0;
      end else if (en) begin
        s_v[k+1] <= s_v[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        s_rem[k+1]  <= rs[SW+1:0];
        s_root[k+1] <= rn;
        s_sq[k+1]   <= s_sq[k];
        s_pre[k+1]  <= s_pre[k];
      end
    end
  end

  // ------------------------------------------------- normalize and classify
  logic [SW-1:0]    len;
  logic [SW+FW-1:0] norm_full;
  logic [FW:0]      norm;
  logic [FW-1:0]    inner_w, outer_w;
  logic [FW+RadW-1:0] inner_x, outer_x;
  logic             div_c;
  logic [FW:0]      const_c;

  assign len       = s_root[SW];
  assign norm_full = {len, {FW{1'b0}}} >> (SW - 1);
  assign norm      = (norm_full > (SW+FW)'(FracOne)) ? FracOne : norm_full[FW:0];
  assign inner_x   = ((FW+RadW)'(inner_i) << Lsh) >> Rsh;
  assign outer_x   = ((FW+RadW)'(outer_i) << Lsh) >> Rsh;
  assign inner_w   = inner_x[FW-1:0];
  assign outer_w   = outer_x[FW-1:0];

  // Step response, dead zone, saturation, or the linear band that needs a divide.
  always_comb begin
    div_c   = 1'b0;
    const_c = '0;
    if (outer_w <= inner_w) begin
      const_c = (norm >= {1'b0, inner_w}) ? FracOne : '0;
    end else if (norm < {1'b0, inner_w}) begin
      const_c = '0;
    end else if (norm > {1'b0, outer_w}) begin
      const_c = FracOne;
    end else begin
      div_c = 1'b1;
    end
  end

  logic             d_v     [FQ+1];
  logic [FW-1:0]    d_r     [FQ+1];
  logic [FW:0]      d_q     [FQ+1];
  logic [FW-1:0]    d_d     [FQ+1];
  logic             d_div   [FQ+1];
  logic [FW:0]      d_const [FQ+1];
  logic [SideW-1:0] d_side  [FQ+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_v[0] <= 1'b0;
    end else if (en) begin
      d_v[0] <= s_v[SW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_r[0]     <= norm[FW-1:0] - inner_w;
      d_q[0]     <= '0;
      d_d[0]     <= outer_w - inner_w;
      d_div[0]   <= div_c;
      d_const[0] <= const_c;
      d_side[0]  <= {len == '0, s_pre[SW], len};
    end
  end

  // ------------------------------------------------------ band divider
  // Restoring division of the band offset by the band width, one bit a stage.
  for (genvar j = 0; j < FQ; j++) begin : g_band
    logic [FW:0] rt, rs;
    logic        qb;

    always_comb begin
      rt = (j == 0) ? {1'b0, d_r[j]} : {d_r[j], 1'b0};
      qb = rt >= {1'b0, d_d[j]};
      rs = qb ? rt - {1'b0, d_d[j]} : rt;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        d_v[j+1] <= 1'b0;
      end else if (en) begin
        d_v[j+1] <= d_v[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        d_r[j+1]     <= rs[FW-1:0];
        d_q[j+1]     <= {d_q[j][FW-1:0], qb};
        d_d[j+1]     <= d_d[j];
        d_div[j+1]   <= d_div[j];
        d_const[j+1] <= d_const[j];
        d_side[j+1]  <= d_side[j];
      end
    end
  end

  // ------------------------------------------------------ response curve
  logic [FW:0]       t_sel;
  logic [2*FW+1:0]   t_sq;
  logic              k1_v, k2_v;
  logic [FW:0]       k1_t, k1_q, k2_s;
  logic [SideW-1:0]  k1_side, k2_side;
  logic [FW+1:0]     k_m;
  logic [2*FW+2:0]   k_prod;
  logic [FW:0]       k_s;

  assign t_sel = d_div[FQ] ? d_q[FQ] : d_const[FQ];
  assign t_sq  = (2*FW+2)'(t_sel) * (2*FW+2)'(t_sel);

  // Smoothstep 3t^2 - 2t^3 built on the registered square.
  assign k_m    = Three - {k1_t, 1'b0};
  assign k_prod = (2*FW+3)'(k1_q) * (2*FW+3)'(k_m);

  always_comb begin
    case (curve_i)
      CurveQuad:   k_s = k1_q;
      CurveSmooth: k_s = k_prod[2*FW:FW];
      CurveLinear: k_s = k1_t;
      default:     k_s = k1_t;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k1_v <= 1'b0;
      k2_v <= 1'b0;
    end else if (en) begin
      k1_v <= d_v[FQ];
      k2_v <= k1_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      k1_t    <= t_sel;
      k1_q    <= t_sq[2*FW:FW];
      k1_side <= d_side[FQ];
      k2_s    <= k_s;
      k2_side <= k1_side;
    end
  end

  // ------------------------------------------------------ axis scaling
  logic                m1_v, m2_v;
  logic [SW+FW:0]      m1_px, m1_py;
  logic [SideW-1:0]    m1_side, m2_side;
  logic [SW+FW+15:0]   n_x, n_y;
  logic [NW-1:0]       m2_nx, m2_ny;

  // Magnitude times shaped length times 32767, then the length scale removed.
  assign n_x = {m1_px, {ScaleW{1'b0}}} - (SW+FW+16)'(m1_px);
  assign n_y = {m1_py, {ScaleW{1'b0}}} - (SW+FW+16)'(m1_py);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v <= 1'b0;
      m2_v <= 1'b0;
    end else if (en) begin
      m1_v <= k2_v;
      m2_v <= m1_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_px   <= (SW+FW+1)'(k2_side[3*SW-1:2*SW]) * (SW+FW+1)'(k2_s);
      m1_py   <= (SW+FW+1)'(k2_side[2*SW-1:SW]) * (SW+FW+1)'(k2_s);
      m1_side <= k2_side;
      m2_nx   <= n_x[FW +: NW];
      m2_ny   <= n_y[FW +: NW];
      m2_side <= m1_side;
    end
  end

  // Quotient is at most 32767 because each magnitude is at most the length.
  logic [SW-1:0]     e_rx   [ScaleW+1];
  logic [SW-1:0]     e_ry   [ScaleW+1];
  logic [ScaleW-1:0] e_qx   [ScaleW+1];
  logic [ScaleW-1:0] e_qy   [ScaleW+1];
  logic [NW-1:0]     e_nx   [ScaleW+1];
  logic [NW-1:0]     e_ny   [ScaleW+1];
  logic [SideW-1:0]  e_side [ScaleW+1];
  logic              e_v    [ScaleW+1];

  assign e_v[0]    = m2_v;
  assign e_rx[0]   = m2_nx[NW-1:ScaleW];
  assign e_ry[0]   = m2_ny[NW-1:ScaleW];
  assign e_qx[0]   = '0;
  assign e_qy[0]   = '0;
  assign e_nx[0]   = m2_nx;
  assign e_ny[0]   = m2_ny;
  assign e_side[0] = m2_side;

  // Two restoring dividers by the vector length, one quotient bit a stage.
  for (genvar j = 0; j < ScaleW; j++) begin : g_scale
    localparam int P = ScaleW - 1 - j;
    logic [SW:0] rtx, rty, lx;
    logic        qx, qy;

    always_comb begin
      lx  = {1'b0, e_side[j][SW-1:0]};
      rtx = {e_rx[j], e_nx[j][P]};
      rty = {e_ry[j], e_ny[j][P]};
      qx  = rtx >= lx;
      qy  = rty >= lx;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        e_v[j+1] <= 1'b0;
      end else if (en) begin
        e_v[j+1] <= e_v[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        e_rx[j+1]   <= qx ? SW'(rtx - lx) : rtx[SW-1:0];
        e_ry[j+1]   <= qy ? SW'(rty - lx) : rty[SW-1:0];
        e_qx[j+1]   <= {e_qx[j][ScaleW-2:0], qx};
        e_qy[j+1]   <= {e_qy[j][ScaleW-2:0], qy};
        e_nx[j+1]   <= e_nx[j];
        e_ny[j+1]   <= e_ny[j];
        e_side[j+1] <= e_side[j];
      end
    end
  end

  // ------------------------------------------------------ output register
  logic             f_zero, f_sx, f_sy;
  logic [OutW-1:0]  f_mx, f_my;

  assign f_zero = e_side[ScaleW][3*SW+2];
  assign f_sx   = e_side[ScaleW][3*SW+1];
  assign f_sy   = e_side[ScaleW][3*SW];
  assign f_mx   = {1'b0, e_qx[ScaleW]};
  assign f_my   = {1'b0, e_qy[ScaleW]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (en) begin
      res_valid_q <= e_v[ScaleW];
    end
  end

  // Zero length gives a centered result; a negative axis takes the negated quotient.
  always_ff @(posedge clk_i) begin
    if (en) begin
      res_x_q <= f_zero ? '0 : (f_sx ? -f_mx : f_mx);
      res_y_q <= f_zero ? '0 : (f_sy ? -f_my : f_my);
    end
  end

  assign result_o.valid = res_valid_q;
  assign result_o.out_x = res_x_q;
  assign result_o.out_y = res_y_q;

  // ------------------------------------------------------ assertions
  a_sqrt_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_v[SW] |-> ((2*SW+2)'(len) * (2*SW+2)'(len) <= (2*SW+2)'(s_sq[SW])) &&
                (((2*SW+2)'(len) + 1'b1) * ((2*SW+2)'(len) + 1'b1) > (2*SW+2)'(s_sq[SW])))
    else $error("square root stage result out of range");

  a_band_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (d_v[FQ] && d_div[FQ]) |-> (d_q[FQ] <= FracOne))
    else $error("band quotient above one");

  a_scale_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (e_v[ScaleW] && !f_zero) |-> (e_rx[ScaleW] < e_side[ScaleW][SW-1:0]) &&
                                  (e_ry[ScaleW] < e_side[ScaleW][SW-1:0]))
    else $error("scale divider remainder not below length");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> res_valid_q && $stable(res_x_q) && $stable(res_y_q))
    else $error("pipeline moved during output stall");

endmodule

`default_nettype wire

>>> src/radial_stick_deadzone_shaper.sv
// Channel   Direction  Payload                       Transfer
// sample_i  in         raw_x, raw_y                  valid && ready
// result_o  out        out_x, out_y (signed)         valid && ready
// cfg_i     in         index, data                   valid && ready (always ready)
//
// One item is accepted per cycle unless an output stall has filled the queue.
// Back pipeline: bit-per-stage square root, band divider, two scaling dividers.
// Reset clears pipeline valid bits and the queue; config registers take reset values.
// An output stall freezes the back pipeline; the two-entry queue and the front stage
// keep accepting items until they are full.
`default_nettype none

module radial_stick_deadzone_shaper import rsds_pkg::*; #(
  parameter int SAMPLE_BITS   = 12,
  parameter int FRACTION_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  rsds_sample_if.sink    sample_i,
  rsds_result_if.source  result_o,
  rsds_cfg_if.sink       cfg_i
);

  localparam int QW = 4*SAMPLE_BITS + 2;

  logic [RadW-1:0]   inner_q, outer_q;
  logic [CurveW-1:0] curve_q;
  logic              push_valid, push_ready, pop_valid, pop_ready;
  logic [QW-1:0]     push_data, pop_data;

  // Configuration registers; writes to unknown indexes are dropped.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inner_q <= InnerReset;
      outer_q <= OuterReset;
      curve_q <= CurveLinear;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgInner: inner_q <= cfg_i.data;
        CfgOuter: outer_q <= cfg_i.data;
        CfgCurve: curve_q <= cfg_i.data[CurveW-1:0];
        default: begin
        end
      endcase
    end
  end

  rsds_front #(.SW(SAMPLE_BITS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sample_i     (sample_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  rsds_fifo #(.W(QW)) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  rsds_back #(.SW(SAMPLE_BITS), .FW(FRACTION_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .inner_i     (inner_q),
    .outer_i     (outer_q),
    .curve_i     (curve_q),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`default_nettype none

module tb_top;
  import rsds_pkg::*;

  localparam int SampleW    = 12;
  localparam int FracBits   = 16;
  localparam int LatencyCyc = SampleW + FracBits + 24;
  localparam int CycleLimit = 200000;
  localparam int PhaseItems = 45;
  localparam logic [CfgIdxW-1:0] CfgUnused  = 2'd3;
  localparam logic [CurveW-1:0]  CurveSpare = 2'd3;

  typedef struct packed {
    logic signed [OutW-1:0] out_x;
    logic signed [OutW-1:0] out_y;
  } deflection_t;

  // Tracks the register settings and the deflections still owed by the block.
  class deflection_board;
    logic [RadW-1:0]   inner_r;
    logic [RadW-1:0]   outer_r;
    logic [CurveW-1:0] curve_r;
    deflection_t       pending_q[$];
    int                errors;
    int                checked;

    function new();
      inner_r = InnerReset;
      outer_r = OuterReset;
      curve_r = CurveLinear;
      errors  = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgInner: inner_r = data[RadW-1:0];
        CfgOuter: outer_r = data[RadW-1:0];
        CfgCurve: curve_r = data[CurveW-1:0];
        default: ;
      endcase
    endfunction

    // Scales one centered axis by shaped/len, truncating toward zero.
    function logic signed [OutW-1:0] scale_axis(longint c, longint unsigned s,
                                                longint unsigned len);
      longint unsigned mag;
      longint unsigned q;
      mag = (c < 0) ? longint'(-c) : longint'(c);
      q = (mag * s * 64'd32767) / (len << FracBits);
      if (c < 0) begin
        return (q > 32768) ? -16'sd32768 : -$signed(q[OutW-1:0]);
      end
      return (q > 32767) ? 16'sd32767 : $signed(q[OutW-1:0]);
    endfunction

    function deflection_t shape_stick(logic [SampleW-1:0] rx, logic [SampleW-1:0] ry);
      longint          cx, cy;
      longint unsigned sq, len, probe, norm, shaped, lo, hi, one, sqr;
      deflection_t     res;
      one = 64'd1 << FracBits;
      cx = longint'(rx) - 2048;
      cy = longint'(ry) - 2048;
      sq = cx * cx + cy * cy;
      // Bitwise floor square root.
      len = 0;
      probe = 64'd1 << 62;
      while (probe > sq) probe >>= 2;
      while (probe != 0) begin
        if (sq >= len + probe) begin
          sq -= len + probe;
          len = (len >> 1) + probe;
        end else begin
          len >>= 1;
        end
        probe >>= 2;
      end
      if (len == 0) begin
        res.out_x = '0;
        res.out_y = '0;
        return res;
      end
      norm = (len << FracBits) / 2048;
      if (norm > one) norm = one;
      lo = inner_r;
      hi = outer_r;
      // Deadzone band; a collapsed band degenerates to a step.
      if (hi <= lo) shaped = (norm >= lo) ? one : 0;
      else if (norm < lo) shaped = 0;
      else if (norm > hi) shaped = one;
      else shaped = ((norm - lo) << FracBits) / (hi - lo);
      sqr = (shaped * shaped) >> FracBits;
      if (curve_r == CurveQuad) shaped = sqr;
      else if (curve_r == CurveSmooth) shaped = (sqr * (3 * one - 2 * shaped)) >> FracBits;
      res.out_x = scale_axis(cx, shaped, len);
      res.out_y = scale_axis(cy, shaped, len);
      return res;
    endfunction

    function void note_sample(logic [SampleW-1:0] rx, logic [SampleW-1:0] ry);
      pending_q.push_back(shape_stick(rx, ry));
    endfunction

    function void check_result(logic signed [OutW-1:0] ax, logic signed [OutW-1:0] ay);
      deflection_t exp_d;
      if (pending_q.size() == 0) begin
        $error("unexpected result out_x=%0d out_y=%0d", ax, ay);
        errors++;
        return;
      end
      exp_d = pending_q.pop_front();
      checked++;
      if (ax !== exp_d.out_x) begin
        $error("out_x expected %0d actual %0d", exp_d.out_x, ax);
        errors++;
      end
      if (ay !== exp_d.out_y) begin
        $error("out_y expected %0d actual %0d", exp_d.out_y, ay);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   steady;
  int   cycles;
  int   sent;
  deflection_board board;

  rsds_sample_if #(.SW(SampleW)) sample_if ();
  rsds_result_if result_if ();
  rsds_cfg_if    cfg_if ();

  radial_stick_deadzone_shaper #(
    .SAMPLE_BITS  (SampleW),
    .FRACTION_BITS(FracBits)
  ) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sample_i(sample_if),
    .result_o(result_if),
    .cfg_i   (cfg_if)
  );

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Result side: check accepted items, then pick the next ready level.
  always @(posedge clk_i) begin
    if (rst_ni && result_if.valid && result_if.ready) begin
      board.check_result(result_if.out_x, result_if.out_y);
    end
    result_if.ready <= steady || ($urandom_range(0, 99) >= 13);
  end

  // Run watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_sample(logic [SampleW-1:0] rx, logic [SampleW-1:0] ry);
    while (!steady && $urandom_range(0, 99) < 13) begin
      sample_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_if.valid <= 1'b1;
    sample_if.raw_x <= rx;
    sample_if.raw_y <= ry;
    do @(posedge clk_i); while (!sample_if.ready);
    board.note_sample(rx, ry);
    sent++;
  endtask

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    board.write_reg(idx, data);
  endtask

  // Lets the pipeline drain completely before touching the registers.
  task automatic drain();
    sample_if.valid <= 1'b0;
    cfg_if.valid    <= 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (LatencyCyc + 8) @(posedge clk_i);
  endtask

  task automatic send_random();
    logic [SampleW-1:0] rx, ry;
    int                 r;
    case ($urandom_range(0, 9))
      6: begin
        r  = $urandom_range(1, 300);
        rx = 12'(2048 + $urandom_range(0, 2 * r) - r);
        ry = 12'(2048 + $urandom_range(0, 2 * r) - r);
      end
      7: begin
        rx = ($urandom_range(0, 2) == 0) ? 12'd0 : ($urandom_range(0, 1) ? 12'd4095 : 12'd2048);
        ry = ($urandom_range(0, 2) == 0) ? 12'd0 : ($urandom_range(0, 1) ? 12'd4095 : 12'd2048);
      end
      8: begin
        rx = $urandom_range(0, 1) ? 12'd0 : 12'd4095;
        ry = 12'($urandom_range(0, 4095));
      end
      9: begin
        rx = 12'd2048;
        ry = 12'd2048;
      end
      default: begin
        rx = 12'($urandom_range(0, 4095));
        ry = 12'($urandom_range(0, 4095));
      end
    endcase
    send_sample(rx, ry);
  endtask

  task automatic set_regs(logic [RadW-1:0] inn, logic [RadW-1:0] outr,
                          logic [CfgDataW-1:0] curve);
    write_cfg(CfgInner, inn);
    write_cfg(CfgOuter, outr);
    write_cfg(CfgCurve, curve);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    board = new();
    steady = 1'b0;
    sent = 0;
    rst_ni = 1'b0;
    sample_if.valid = 1'b0;
    sample_if.raw_x = '0;
    sample_if.raw_y = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // Reset settings: centered stick, axis extremes, corners, tiny offsets, band edges.
    send_sample(12'd2048, 12'd2048);
    send_sample(12'd0, 12'd0);
    send_sample(12'd4095, 12'd4095);
    send_sample(12'd0, 12'd4095);
    send_sample(12'd4095, 12'd0);
    send_sample(12'd0, 12'd2048);
    send_sample(12'd4095, 12'd2048);
    send_sample(12'd2048, 12'd0);
    send_sample(12'd2048, 12'd4095);
    send_sample(12'd2049, 12'd2048);
    send_sample(12'd2047, 12'd2047);
    send_sample(12'd2048 + 12'd205, 12'd2048);
    send_sample(12'd2048 - 12'd204, 12'd2048);
    send_sample(12'd2048 + 12'd1946, 12'd2048);
    send_sample(12'd2048, 12'd2048 - 12'd1946);
    send_sample(12'd2900, 12'd1200);
    repeat (PhaseItems - 16) send_random();

    for (int phase = 1; phase <= 8; phase++) begin
      drain();
      case (phase)
        1: set_regs(16'd0, 16'd65535, CfgDataW'(CurveLinear));
        2: set_regs(16'd6554, 16'd62259, CfgDataW'(CurveQuad));
        3: set_regs(16'd16384, 16'd49152, CfgDataW'(CurveSmooth));
        4: set_regs(16'd65535, 16'd0, CfgDataW'(CurveSpare));
        5: set_regs(16'd30000, 16'd30000, CfgDataW'(CurveLinear));
        6: set_regs(16'd0, 16'd0, CfgDataW'(CurveQuad));
        7: begin
          set_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)));
          // An unmapped index must leave the registers alone.
          write_cfg(CfgUnused, 16'($urandom_range(0, 65535)));
          cfg_if.valid <= 1'b0;
        end
        default: set_regs(16'd1, 16'd65534, 16'hFFFE);
      endcase
      steady = (phase == 3);
      for (int n = 0; n < PhaseItems; n++) begin
        // Hold the sender off until the block has emptied once mid-phase.
        if (phase == 5 && n == PhaseItems / 2) begin
          sample_if.valid <= 1'b0;
          while (board.pending_q.size() != 0) @(posedge clk_i);
        end
        send_random();
      end
      steady = 1'b0;
    end

    sample_if.valid <= 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (LatencyCyc + 8) @(posedge clk_i);

    $display("tb: %0d stick samples sent over 9 register settings, %0d results checked",
             sent, board.checked);
    $display("tb: settings covered curve codes, collapsed bands and full-range deadzones");
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
src/rsds_pkg.sv
src/rsds_if.sv
src/rsds_front.sv
src/rsds_fifo.sv
src/rsds_back.sv
src/radial_stick_deadzone_shaper.sv
tb/tb_top.sv
